/* src/pfx_pkg.sv */
// Shared types and constants for the postfix expression evaluator.
package pfx_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int DATA_W = 32;
	localparam int SYM_W = 8;
	localparam int SP_W = $clog2(STACK_DEPTH + 1);
	localparam int IDX_W = $clog2(STACK_DEPTH);
	localparam int CNT_W = $clog2(DATA_W);

	localparam logic [SYM_W-1:0] SYM_ZERO = 8'h30;
	localparam logic [SYM_W-1:0] SYM_NINE = 8'h39;
	localparam logic [SYM_W-1:0] SYM_DIV = 8'h2F;
	localparam logic [SYM_W-1:0] SYM_MUL = 8'h2A;
	localparam logic [SYM_W-1:0] SYM_ADD = 8'h2B;

	typedef enum logic [1:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_MUL,
		ALU_DIV
	} alu_op_t;

	typedef enum logic [2:0] {
		A_IDLE,
		A_ONE,
		A_NEGA,
		A_NEGB,
		A_ITER,
		A_FIX
	} alu_state_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOAD,
		S_EXEC,
		S_FINISH
	} seq_state_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

	typedef struct packed {
		logic done;
		logic dz;
	} alu_rsp_t;

endpackage

/* src/pfx_stack_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module pfx_stack_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* src/pfx_alu.sv */
// Iterative arithmetic unit: one shared adder serves add, subtract, multiply and divide.
module pfx_alu (
	input  logic                         clk,
	input  logic                         arst_n,
	input  pfx_pkg::alu_req_t            req,
	input  logic [pfx_pkg::DATA_W-1:0]   a,
	input  logic [pfx_pkg::DATA_W-1:0]   b,
	output pfx_pkg::alu_rsp_t            rsp,
	output logic [pfx_pkg::DATA_W-1:0]   result
);

	pfx_pkg::alu_state_t state_q, state_d;
	pfx_pkg::alu_op_t op_q;
	logic [pfx_pkg::DATA_W-1:0] r_q;
	logic [pfx_pkg::DATA_W-1:0] d_q;
	logic [pfx_pkg::DATA_W-1:0] q_q;
	logic [pfx_pkg::CNT_W-1:0] cnt_q;
	logic neg_q;
	logic done_q;
	logic dz_q;
	logic [pfx_pkg::DATA_W:0] add_x;
	logic [pfx_pkg::DATA_W:0] add_y;
	logic add_sub;
	logic [pfx_pkg::DATA_W:0] sum;
	logic last_iter;

	assign last_iter = (cnt_q == pfx_pkg::CNT_W'(pfx_pkg::DATA_W - 1));

	// The one adder; subtraction is done by inverting y and carrying in.
	always_comb begin
		add_x = {1'b0, r_q};
		add_y = {1'b0, d_q};
		add_sub = 1'b0;
		unique case (state_q)
			pfx_pkg::A_ONE: begin
				add_sub = (op_q == pfx_pkg::ALU_SUB);
			end
			pfx_pkg::A_NEGA: begin
				add_x = '0;
				add_y = {1'b0, r_q};
				add_sub = 1'b1;
			end
			pfx_pkg::A_NEGB: begin
				add_x = '0;
				add_sub = 1'b1;
			end
			pfx_pkg::A_ITER: begin
				if (op_q == pfx_pkg::ALU_DIV) begin
					add_x = {r_q, q_q[pfx_pkg::DATA_W-1]};
					add_sub = 1'b1;
				end
			end
			pfx_pkg::A_FIX: begin
				add_x = '0;
				add_y = {1'b0, q_q};
				add_sub = 1'b1;
			end
			default: begin
			end
		endcase
		sum = add_x + (add_sub ? ~add_y : add_y) + {{pfx_pkg::DATA_W{1'b0}}, add_sub};
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pfx_pkg::A_IDLE: begin
				if (req.start) begin
					unique case (req.op)
						pfx_pkg::ALU_ADD, pfx_pkg::ALU_SUB: state_d = pfx_pkg::A_ONE;
						pfx_pkg::ALU_MUL: state_d = pfx_pkg::A_ITER;
						pfx_pkg::ALU_DIV: begin
							state_d = (b == '0) ? pfx_pkg::A_IDLE : pfx_pkg::A_NEGA;
						end
						default: state_d = pfx_pkg::A_IDLE;
					endcase
				end
			end
			pfx_pkg::A_ONE: state_d = pfx_pkg::A_IDLE;
			pfx_pkg::A_NEGA: state_d = pfx_pkg::A_NEGB;
			pfx_pkg::A_NEGB: state_d = pfx_pkg::A_ITER;
			pfx_pkg::A_ITER: begin
				if (last_iter) begin
					state_d = (op_q == pfx_pkg::ALU_DIV) ? pfx_pkg::A_FIX : pfx_pkg::A_IDLE;
				end
			end
			pfx_pkg::A_FIX: state_d = pfx_pkg::A_IDLE;
			default: state_d = pfx_pkg::A_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pfx_pkg::A_IDLE;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= 1'b0;
			if (state_q == pfx_pkg::A_IDLE && req.start && req.op == pfx_pkg::ALU_DIV
					&& b == '0) begin
				done_q <= 1'b1;
			end
			if (state_q == pfx_pkg::A_ONE || state_q == pfx_pkg::A_FIX) begin
				done_q <= 1'b1;
			end
			if (state_q == pfx_pkg::A_ITER && last_iter && op_q == pfx_pkg::ALU_MUL) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			pfx_pkg::A_IDLE: begin
				if (req.start) begin
					op_q <= req.op;
					cnt_q <= '0;
					neg_q <= a[pfx_pkg::DATA_W-1] ^ b[pfx_pkg::DATA_W-1];
					dz_q <= 1'b0;
					r_q <= a;
					d_q <= b;
					q_q <= b;
					if (req.op == pfx_pkg::ALU_MUL) begin
						r_q <= '0;
						d_q <= a;
					end
					if (req.op == pfx_pkg::ALU_DIV && b == '0) begin
						r_q <= '0;
						dz_q <= 1'b1;
					end
				end
			end
			pfx_pkg::A_ONE: begin
				r_q <= sum[pfx_pkg::DATA_W-1:0];
			end
			pfx_pkg::A_NEGA: begin
				q_q <= r_q[pfx_pkg::DATA_W-1] ? sum[pfx_pkg::DATA_W-1:0] : r_q;
			end
			pfx_pkg::A_NEGB: begin
				if (d_q[pfx_pkg::DATA_W-1]) begin
					d_q <= sum[pfx_pkg::DATA_W-1:0];
				end
				r_q <= '0;
			end
			pfx_pkg::A_ITER: begin
				cnt_q <= cnt_q + pfx_pkg::CNT_W'(1);
				if (op_q == pfx_pkg::ALU_DIV) begin
					// Restoring step: keep the difference only when it did not borrow.
					if (!sum[pfx_pkg::DATA_W]) begin
						r_q <= sum[pfx_pkg::DATA_W-1:0];
					end else begin
						r_q <= {r_q[pfx_pkg::DATA_W-2:0], q_q[pfx_pkg::DATA_W-1]};
					end
					q_q <= {q_q[pfx_pkg::DATA_W-2:0], ~sum[pfx_pkg::DATA_W]};
				end else begin
					if (q_q[0]) begin
						r_q <= sum[pfx_pkg::DATA_W-1:0];
					end
					d_q <= {d_q[pfx_pkg::DATA_W-2:0], 1'b0};
					q_q <= {1'b0, q_q[pfx_pkg::DATA_W-1:1]};
				end
			end
			pfx_pkg::A_FIX: begin
				r_q <= neg_q ? sum[pfx_pkg::DATA_W-1:0] : q_q;
			end
			default: begin
			end
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.dz = dz_q;
	assign result = r_q;

endmodule

/* src/postfix_expression_evaluator_top.sv */
// Top level: stack sequencer, value stack RAM, shared ALU and output register.
//
// Usage: one postfix symbol is transferred per input item on in_valid/in_stall.
// A digit pushes its value; '/', '*' and '+' operate on the two top values;
// any other byte subtracts. Every input item yields exactly one result on
// out_valid/out_stall: the new top of stack, an empty flag, and the overflow,
// underflow and divide-by-zero flags for that item.
// The pace is set by the sequencer and the iterative ALU (one adder step per
// cycle): a digit needs no ALU step, add or subtract takes one adder step,
// multiply 32 shift-add steps, and divide two negations, 32 restoring steps
// and a sign fix; a zero divisor skips these steps.
// One item is worked at a time;
// in_stall is high until the item's result sits in the output register.
// The output register lets the next item be taken while a result waits.
// A finished item waits in place while out_stall holds the previous result.
// Reset empties the stack at once; stack contents are never cleared, only
// entries below the stack pointer are read.
module postfix_expression_evaluator_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [pfx_pkg::SYM_W-1:0]         symbol,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [pfx_pkg::DATA_W-1:0] top_value,
	output logic                              stack_empty,
	output logic                              overflow,
	output logic                              underflow,
	output logic                              divide_by_zero
);

	pfx_pkg::seq_state_t state_q, state_d;
	logic [pfx_pkg::SP_W-1:0] sp_q;
	logic [pfx_pkg::DATA_W-1:0] top_q;
	logic [pfx_pkg::DATA_W-1:0] right_q;
	logic left_ok_q;
	pfx_pkg::alu_op_t op_q;
	logic ovf_q;
	logic unf_q;
	logic dz_q;

	logic out_valid_q;
	logic [pfx_pkg::DATA_W-1:0] out_top_q;
	logic out_empty_q;
	logic out_ovf_q;
	logic out_unf_q;
	logic out_dz_q;

	logic in_xfer;
	logic out_free;
	logic is_digit;
	logic sp_full;
	logic sp_ge2;
	pfx_pkg::alu_op_t dec_op;

	logic ram_wr_en;
	logic [pfx_pkg::IDX_W-1:0] ram_wr_addr;
	logic [pfx_pkg::DATA_W-1:0] ram_wr_data;
	logic ram_rd_en;
	logic [pfx_pkg::IDX_W-1:0] ram_rd_addr;
	logic [pfx_pkg::DATA_W-1:0] ram_rd_data;

	pfx_pkg::alu_req_t alu_req;
	pfx_pkg::alu_rsp_t alu_rsp;
	logic [pfx_pkg::DATA_W-1:0] alu_a;
	logic [pfx_pkg::DATA_W-1:0] alu_result;
	logic [pfx_pkg::DATA_W-1:0] digit_value;
	logic [pfx_pkg::SP_W-1:0] sp_minus2;
	logic [pfx_pkg::SP_W-1:0] sp_minus1;

	assign is_digit = (symbol >= pfx_pkg::SYM_ZERO) && (symbol <= pfx_pkg::SYM_NINE);
	assign sp_full = (sp_q >= pfx_pkg::SP_W'(pfx_pkg::STACK_DEPTH));
	assign sp_ge2 = (sp_q >= pfx_pkg::SP_W'(2));
	assign sp_minus2 = sp_q - pfx_pkg::SP_W'(2);
	assign sp_minus1 = sp_q - pfx_pkg::SP_W'(1);
	assign digit_value = pfx_pkg::DATA_W'(symbol - pfx_pkg::SYM_ZERO);
	assign out_free = !out_valid_q || !out_stall;
	assign in_xfer = in_valid && !in_stall;
	assign alu_a = left_ok_q ? ram_rd_data : '0;

	always_comb begin
		case (symbol)
			pfx_pkg::SYM_DIV: dec_op = pfx_pkg::ALU_DIV;
			pfx_pkg::SYM_MUL: dec_op = pfx_pkg::ALU_MUL;
			pfx_pkg::SYM_ADD: dec_op = pfx_pkg::ALU_ADD;
			default: dec_op = pfx_pkg::ALU_SUB;
		endcase
	end

	always_comb begin
		state_d = state_q;
		in_stall = 1'b1;
		alu_req.start = 1'b0;
		alu_req.op = op_q;
		ram_rd_en = 1'b0;
		ram_rd_addr = sp_minus2[pfx_pkg::IDX_W-1:0];
		ram_wr_en = 1'b0;
		ram_wr_addr = sp_q[pfx_pkg::IDX_W-1:0];
		ram_wr_data = digit_value;
		unique case (state_q)
			pfx_pkg::S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (is_digit) begin
						ram_wr_en = !sp_full;
						state_d = pfx_pkg::S_FINISH;
					end else begin
						// The left operand sits one below the cached top.
						ram_rd_en = sp_ge2;
						state_d = pfx_pkg::S_LOAD;
					end
				end
			end
			pfx_pkg::S_LOAD: begin
				alu_req.start = 1'b1;
				state_d = pfx_pkg::S_EXEC;
			end
			pfx_pkg::S_EXEC: begin
				if (alu_rsp.done) begin
					ram_wr_en = 1'b1;
					ram_wr_addr = sp_minus1[pfx_pkg::IDX_W-1:0];
					ram_wr_data = alu_result;
					state_d = pfx_pkg::S_FINISH;
				end
			end
			pfx_pkg::S_FINISH: begin
				if (out_free) begin
					state_d = pfx_pkg::S_IDLE;
				end
			end
			default: state_d = pfx_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pfx_pkg::S_IDLE;
			sp_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_xfer) begin
				if (is_digit) begin
					if (!sp_full) begin
						sp_q <= sp_q + pfx_pkg::SP_W'(1);
					end
				end else begin
					// Pop two, push one; missing operands leave a single entry.
					sp_q <= sp_ge2 ? sp_minus1 : pfx_pkg::SP_W'(1);
				end
			end
			if (state_q == pfx_pkg::S_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			ovf_q <= 1'b0;
			unf_q <= 1'b0;
			dz_q <= 1'b0;
			if (is_digit) begin
				if (sp_full) begin
					ovf_q <= 1'b1;
				end else begin
					top_q <= digit_value;
				end
			end else begin
				op_q <= dec_op;
				unf_q <= !sp_ge2;
				left_ok_q <= sp_ge2;
				right_q <= (sp_q != '0) ? top_q : '0;
			end
		end
		if (state_q == pfx_pkg::S_EXEC && alu_rsp.done) begin
			top_q <= alu_result;
			dz_q <= alu_rsp.dz;
		end
		if (state_q == pfx_pkg::S_FINISH && out_free) begin
			out_top_q <= (sp_q == '0) ? '0 : top_q;
			out_empty_q <= (sp_q == '0);
			out_ovf_q <= ovf_q;
			out_unf_q <= unf_q;
			out_dz_q <= dz_q;
		end
	end

	pfx_stack_ram #(
		.DEPTH(pfx_pkg::STACK_DEPTH),
		.WIDTH(pfx_pkg::DATA_W)
	) u_stack (
		.clk(clk),
		.wr_en(ram_wr_en),
		.wr_addr(ram_wr_addr),
		.wr_data(ram_wr_data),
		.rd_en(ram_rd_en),
		.rd_addr(ram_rd_addr),
		.rd_data(ram_rd_data)
	);

	pfx_alu u_alu (
		.clk(clk),
		.arst_n(arst_n),
		.req(alu_req),
		.a(alu_a),
		.b(right_q),
		.rsp(alu_rsp),
		.result(alu_result)
	);

	assign out_valid = out_valid_q;
	assign top_value = out_top_q;
	assign stack_empty = out_empty_q;
	assign overflow = out_ovf_q;
	assign underflow = out_unf_q;
	assign divide_by_zero = out_dz_q;

	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= pfx_pkg::SP_W'(pfx_pkg::STACK_DEPTH))
		else $error("stack pointer beyond stack depth");

	a_done_in_exec: assert property (@(posedge clk) disable iff (!arst_n)
		alu_rsp.done |-> state_q == pfx_pkg::S_EXEC)
		else $error("ALU finished outside the execute state");

	a_op_leaves_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pfx_pkg::S_EXEC && alu_rsp.done) |=> sp_q != '0)
		else $error("operator left the stack empty");

	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && divide_by_zero) |-> (top_value == '0 && !stack_empty))
		else $error("divide by zero did not push zero");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && overflow) |-> (!stack_empty && !underflow && !divide_by_zero))
		else $error("overflow flagged with inconsistent flags");

endmodule

/* tb/sv/postfix_expression_evaluator_top_tb.sv */
// Self-checking testbench for the postfix expression evaluator with its own stack model.
`timescale 1ns / 1ps

module postfix_expression_evaluator_top_tb;

	localparam logic [pfx_pkg::SYM_W-1:0] SYM_SUB = 8'h2D;
	localparam int RANDOM_ITEMS = 500;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int DRAIN_CYCLES = 60;

	typedef struct packed {
		logic signed [pfx_pkg::DATA_W-1:0] top;
		logic                              empty;
		logic                              ovf;
		logic                              unf;
		logic                              dz;
	} rpn_result_t;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              in_valid = 1'b0;
	logic                              in_stall;
	logic [pfx_pkg::SYM_W-1:0]         symbol = '0;
	logic                              out_valid;
	logic                              out_stall = 1'b0;
	logic signed [pfx_pkg::DATA_W-1:0] top_value;
	logic                              stack_empty;
	logic                              overflow;
	logic                              underflow;
	logic                              divide_by_zero;

	logic [pfx_pkg::SYM_W-1:0] symbol_feed [$];
	rpn_result_t               predicted_results [$];
	logic                      in_xfer = 1'b0;
	logic                      bursts_on = 1'b1;
	int                        in_gap = 0;
	int                        out_gap = 0;
	int                        quiet_cycles = 0;
	int                        mismatch_count = 0;

	// Model of the value stack, updated on every accepted input transfer.
	logic [pfx_pkg::DATA_W-1:0] calc_stack [pfx_pkg::STACK_DEPTH];
	int                         calc_depth = 0;

	// Depth as the stimulus generator sees it, used to shape sequences.
	int gen_depth = 0;
	int stim_count = 0;

	postfix_expression_evaluator_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.symbol        (symbol),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.top_value     (top_value),
		.stack_empty   (stack_empty),
		.overflow      (overflow),
		.underflow     (underflow),
		.divide_by_zero(divide_by_zero)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic rpn_result_t evaluate_symbol(input logic [pfx_pkg::SYM_W-1:0] sym);
		rpn_result_t                res;
		logic [pfx_pkg::DATA_W-1:0] rhs;
		logic [pfx_pkg::DATA_W-1:0] lhs;
		logic [pfx_pkg::DATA_W-1:0] val;
		logic [pfx_pkg::DATA_W-1:0] mag_l;
		logic [pfx_pkg::DATA_W-1:0] mag_r;
		logic [pfx_pkg::DATA_W-1:0] quo;
		res = '0;
		if (sym >= pfx_pkg::SYM_ZERO && sym <= pfx_pkg::SYM_NINE) begin
			if (calc_depth < pfx_pkg::STACK_DEPTH) begin
				calc_stack[calc_depth] = pfx_pkg::DATA_W'(sym - pfx_pkg::SYM_ZERO);
				calc_depth++;
			end else begin
				res.ovf = 1'b1;
			end
		end else begin
			// The right operand comes off first; a missing operand reads as zero.
			rhs = '0;
			lhs = '0;
			if (calc_depth > 0) begin
				calc_depth--;
				rhs = calc_stack[calc_depth];
			end else begin
				res.unf = 1'b1;
			end
			if (calc_depth > 0) begin
				calc_depth--;
				lhs = calc_stack[calc_depth];
			end else begin
				res.unf = 1'b1;
			end
			case (sym)
				pfx_pkg::SYM_DIV: begin
					if (rhs == '0) begin
						val = '0;
						res.dz = 1'b1;
					end else begin
						mag_l = lhs[pfx_pkg::DATA_W-1] ? -lhs : lhs;
						mag_r = rhs[pfx_pkg::DATA_W-1] ? -rhs : rhs;
						quo = mag_l / mag_r;
						val = (lhs[pfx_pkg::DATA_W-1] ^ rhs[pfx_pkg::DATA_W-1]) ? -quo : quo;
					end
				end
				pfx_pkg::SYM_MUL: val = lhs * rhs;
				pfx_pkg::SYM_ADD: val = lhs + rhs;
				default: val = lhs - rhs;
			endcase
			calc_stack[calc_depth] = val;
			calc_depth++;
		end
		res.empty = (calc_depth == 0);
		res.top = res.empty ? '0 : calc_stack[calc_depth-1];
		return res;
	endfunction

	task automatic add_symbol(input logic [pfx_pkg::SYM_W-1:0] sym);
		symbol_feed.push_back(sym);
		stim_count++;
		if (sym >= pfx_pkg::SYM_ZERO && sym <= pfx_pkg::SYM_NINE) begin
			if (gen_depth < pfx_pkg::STACK_DEPTH)
				gen_depth++;
		end else begin
			gen_depth = (gen_depth >= 2) ? gen_depth - 1 : 1;
		end
	endtask

	function automatic logic [pfx_pkg::SYM_W-1:0] random_digit();
		return pfx_pkg::SYM_ZERO + pfx_pkg::SYM_W'($urandom_range(0, 9));
	endfunction

	function automatic logic [pfx_pkg::SYM_W-1:0] random_operator();
		logic [pfx_pkg::SYM_W-1:0] sym;
		case ($urandom_range(0, 4))
			0: sym = pfx_pkg::SYM_ADD;
			1: sym = SYM_SUB;
			2: sym = pfx_pkg::SYM_MUL;
			3: sym = pfx_pkg::SYM_DIV;
			default: begin
				// Any byte that is neither a digit nor a named operator subtracts.
				do
					sym = pfx_pkg::SYM_W'($urandom_range(0, 255));
				while ((sym >= pfx_pkg::SYM_ZERO && sym <= pfx_pkg::SYM_NINE) ||
					sym == pfx_pkg::SYM_DIV || sym == pfx_pkg::SYM_MUL ||
					sym == pfx_pkg::SYM_ADD);
			end
		endcase
		return sym;
	endfunction

	// Push past the top of the stack, then fold it back down with operators.
	task automatic fill_until_overflow();
		repeat (pfx_pkg::STACK_DEPTH - gen_depth + $urandom_range(1, 3))
			add_symbol(random_digit());
		while (gen_depth > $urandom_range(1, 4))
			add_symbol(random_operator());
	endtask

	// Build the most negative value as eight to the tenth times two, then divide by minus one.
	task automatic divide_most_negative();
		add_symbol(pfx_pkg::SYM_ZERO + 8'd8);
		repeat (9) begin
			add_symbol(pfx_pkg::SYM_ZERO + 8'd8);
			add_symbol(pfx_pkg::SYM_MUL);
		end
		add_symbol(pfx_pkg::SYM_ZERO + 8'd2);
		add_symbol(pfx_pkg::SYM_MUL);
		add_symbol(pfx_pkg::SYM_ZERO);
		add_symbol(pfx_pkg::SYM_ZERO + 8'd1);
		add_symbol(SYM_SUB);
		add_symbol(pfx_pkg::SYM_DIV);
	endtask

	task automatic check_field(input string name,
		input logic signed [pfx_pkg::DATA_W-1:0] want,
		input logic signed [pfx_pkg::DATA_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// Driver: symbols and output stalls change on the falling edge.
	always @(negedge clk) begin
		if (arst_n) begin
			if (symbol_feed.size() < 50)
				bursts_on = 1'b0;
			else if ($urandom_range(0, 149) == 0)
				bursts_on = !bursts_on;
			if (!in_valid || in_xfer) begin
				if (in_gap > 0) begin
					in_valid <= 1'b0;
					in_gap--;
				end else if (symbol_feed.size() > 0) begin
					symbol <= symbol_feed.pop_front();
					in_valid <= 1'b1;
					if (bursts_on && $urandom_range(0, 5) == 0)
						in_gap = $urandom_range(1, 8);
				end else begin
					in_valid <= 1'b0;
				end
			end
			if (out_gap > 0) begin
				out_stall <= 1'b1;
				out_gap--;
			end else begin
				out_stall <= 1'b0;
				if (bursts_on && $urandom_range(0, 7) == 0)
					out_gap = $urandom_range(1, 8);
			end
		end
	end

	// Monitor: predicts on each input transfer and checks each output transfer.
	always @(posedge clk) begin
		rpn_result_t want;
		if (arst_n) begin
			in_xfer <= in_valid && !in_stall;
			if (in_valid && !in_stall)
				predicted_results.push_back(evaluate_symbol(symbol));
			if (out_valid && !out_stall) begin
				if (predicted_results.size() == 0) begin
					$display("%0t: result transfer with none expected: top_value %0d",
						$time, top_value);
					mismatch_count++;
				end else begin
					want = predicted_results.pop_front();
					check_field("top_value", want.top, top_value);
					check_field("stack_empty", pfx_pkg::DATA_W'(want.empty),
						pfx_pkg::DATA_W'(stack_empty));
					check_field("overflow", pfx_pkg::DATA_W'(want.ovf),
						pfx_pkg::DATA_W'(overflow));
					check_field("underflow", pfx_pkg::DATA_W'(want.unf),
						pfx_pkg::DATA_W'(underflow));
					check_field("divide_by_zero", pfx_pkg::DATA_W'(want.dz),
						pfx_pkg::DATA_W'(divide_by_zero));
				end
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles = 0;
			end else if (quiet_cycles == WATCHDOG_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end else begin
				quiet_cycles++;
			end
		end
	end

	initial begin
		logic [pfx_pkg::SYM_W-1:0] opening [25] = '{
			8'h00, pfx_pkg::SYM_DIV, pfx_pkg::SYM_ADD, pfx_pkg::SYM_ZERO + 8'd9,
			pfx_pkg::SYM_ZERO, pfx_pkg::SYM_DIV, pfx_pkg::SYM_MUL,
			pfx_pkg::SYM_ZERO + 8'd4, pfx_pkg::SYM_ZERO + 8'd9, SYM_SUB,
			pfx_pkg::SYM_ZERO + 8'd2, pfx_pkg::SYM_DIV,
			pfx_pkg::SYM_ZERO + 8'd8, 8'h3A, pfx_pkg::SYM_ZERO,
			pfx_pkg::SYM_ZERO + 8'd3, SYM_SUB, pfx_pkg::SYM_DIV,
			pfx_pkg::SYM_ZERO + 8'd8, pfx_pkg::SYM_MUL, 8'hFF,
			pfx_pkg::SYM_ZERO + 8'd5, pfx_pkg::SYM_DIV, 8'h80, 8'h2E
		};
		int pick;

		// Empty-stack operators, zero divisors, signed division and boundary bytes.
		foreach (opening[i])
			add_symbol(opening[i]);

		fill_until_overflow();
		divide_most_negative();
		while (stim_count < RANDOM_ITEMS + $size(opening)) begin
			pick = $urandom_range(0, 99);
			if (pick == 0) begin
				fill_until_overflow();
			end else if (pick == 1 && gen_depth < pfx_pkg::STACK_DEPTH - 4) begin
				divide_most_negative();
			end else if (pick < 16) begin
				add_symbol(pfx_pkg::SYM_W'($urandom_range(0, 255)));
			end else if ($urandom_range(0, 99) < (gen_depth < 3 ? 60 : 40)) begin
				add_symbol(random_digit());
			end else begin
				add_symbol(random_operator());
			end
		end

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		while (symbol_feed.size() != 0 || in_valid || predicted_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && predicted_results.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
